@@ src/pidct_pkg.sv @@
// Package for the clamped-term PID controller: widths, codes, the structs passed
// between the front, the term queue and the back, and the clamp helper.
// No dependencies.
package pidct_pkg;

    // Word widths.
    localparam int DATA_W    = 16;
    localparam int WIDE_W    = DATA_W + 1;
    localparam int FRAC_W    = 8;
    localparam int CFG_IDX_W = 3;

    // Default depth of the term queue and of the result queue.
    localparam int QUEUE_DEPTH_DEF = 4;

    // Operation codes of an input word.
    typedef enum logic {
        OP_UPDATE = 1'b0,
        OP_CLEAR  = 1'b1
    } t_op;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_PROP   = 3'd0,
        REG_GAIN_INTEG  = 3'd1,
        REG_GAIN_DERIV  = 3'd2,
        REG_ERR_LOWER   = 3'd3,
        REG_ERR_UPPER   = 3'd4,
        REG_INTEG_LOWER = 3'd5,
        REG_INTEG_UPPER = 3'd6
    } t_reg_idx;

    // Clamp limits used by the front.
    typedef struct packed {
        logic signed [DATA_W-1:0] err_lower;
        logic signed [DATA_W-1:0] err_upper;
        logic signed [DATA_W-1:0] integ_lower;
        logic signed [DATA_W-1:0] integ_upper;
    } t_clamp_cfg;

    // Gains used by the back, signed Q8.8.
    typedef struct packed {
        logic signed [DATA_W-1:0] prop;
        logic signed [DATA_W-1:0] integ;
        logic signed [DATA_W-1:0] deriv;
    } t_gain_cfg;

    // The three terms of one update, handed from front to back.
    typedef struct packed {
        logic signed [DATA_W-1:0] perr;
        logic signed [DATA_W-1:0] integ;
        logic signed [WIDE_W-1:0] derr;
    } t_terms;

    // Clamp a 17-bit value to 16-bit limits; the lower test comes first,
    // so inverted limits give the lower limit for values below it.
    function automatic logic signed [DATA_W-1:0] clamp_lim(
        input logic signed [WIDE_W-1:0] v,
        input logic signed [DATA_W-1:0] lo,
        input logic signed [DATA_W-1:0] hi
    );
        logic signed [DATA_W-1:0] res;
        if (v < WIDE_W'(lo)) begin
            res = lo;
        end else if (v > WIDE_W'(hi)) begin
            res = hi;
        end else begin
            res = v[DATA_W-1:0];
        end
        return res;
    endfunction

endpackage

@@ src/pid_loop_clamped_terms.sv @@
// Clamped-term PID controller, top level. A result word is visible once its
// update word has passed the term queue, product registers and result queue.
// Throughput: one word per cycle unless a queue stalls; the front integral loop
// closes through its register and the three back multipliers are registered.
// Reset: synchronous active low; integral and previous measurement go to zero,
// gains to zero, clamp limits to full range, and both queues empty.
module pid_loop_clamped_terms
    import pidct_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     push,
    output logic                     full,
    input  logic                     i_operation,
    input  logic signed [DATA_W-1:0] i_target,
    input  logic signed [DATA_W-1:0] i_measured,
    output logic                     empty,
    input  logic                     pop,
    output logic signed [DATA_W-1:0] o_drive,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [DATA_W-1:0]        i_cfg_data
);
    localparam int TERMS_W = $bits(t_terms);

    t_clamp_cfg r_clamp;
    t_gain_cfg  r_gain;
    logic       q_push;
    t_terms     q_wdata;
    logic       q_pop;
    logic [TERMS_W-1:0] q_rdata;
    logic       q_full;
    logic       q_empty;
    logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain.prop         <= '0;
            r_gain.integ        <= '0;
            r_gain.deriv        <= '0;
            r_clamp.err_lower   <= 16'sh8000;
            r_clamp.err_upper   <= 16'sh7FFF;
            r_clamp.integ_lower <= 16'sh8000;
            r_clamp.integ_upper <= 16'sh7FFF;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_GAIN_PROP:   r_gain.prop         <= i_cfg_data;
                REG_GAIN_INTEG:  r_gain.integ        <= i_cfg_data;
                REG_GAIN_DERIV:  r_gain.deriv        <= i_cfg_data;
                REG_ERR_LOWER:   r_clamp.err_lower   <= i_cfg_data;
                REG_ERR_UPPER:   r_clamp.err_upper   <= i_cfg_data;
                REG_INTEG_LOWER: r_clamp.integ_lower <= i_cfg_data;
                REG_INTEG_UPPER: r_clamp.integ_upper <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Front: accept and classify words, run the integrator.
    pidct_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_operation (i_operation),
        .i_target    (i_target),
        .i_measured  (i_measured),
        .i_clamp     (r_clamp),
        .i_q_full    (q_full),
        .o_full      (full),
        .o_q_push    (q_push),
        .o_q_data    (q_wdata)
    );

    // Term queue between front and back.
    pidct_fifo #(
        .WIDTH (TERMS_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_term_q (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_wdata),
        .i_pop       (q_pop),
        .o_pop_data  (q_rdata),
        .o_full      (q_full),
        .o_empty     (q_empty),
        .o_count     (q_count)
    );

    // Back: gains, scaling, saturation and the result queue.
    pidct_back #(
        .OUT_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_gain    (r_gain),
        .i_q_empty (q_empty),
        .i_q_data  (t_terms'(q_rdata)),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_drive   (o_drive)
    );

    // The term queue count agrees with its empty flag.
    a_term_q_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_empty == (q_count == '0))
        else $error("term queue count and empty flag disagree");

endmodule

@@ src/pidct_fifo.sv @@
// Small first-in first-out queue built from flip-flops, used between the
// front and the back and for finished results. Depends on nothing.
module pidct_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_push_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_pop_data,
    output logic             o_full,
    output logic             o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             wr_en;
    logic             rd_en;

    // Handshake qualification.
    assign wr_en = i_push & ~o_full;
    assign rd_en = i_pop & ~o_empty;

    assign o_full     = (r_count == CNT_W'(DEPTH));
    assign o_empty    = (r_count == '0);
    assign o_count    = r_count;
    assign o_pop_data = r_mem[r_rd_ptr];

    // Pointer advance with wrap at the depth.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + CNT_W'(1);
        end else if (rd_en && !wr_en) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

@@ src/pidct_front.sv @@
// Front of the PID controller: accepts words, clamps the error, updates the
// integral and previous measurement, and queues the terms. Uses pidct_pkg.
module pidct_front
    import pidct_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  logic                     i_operation,
    input  logic signed [DATA_W-1:0] i_target,
    input  logic signed [DATA_W-1:0] i_measured,
    input  t_clamp_cfg               i_clamp,
    input  logic                     i_q_full,
    output logic                     o_full,
    output logic                     o_q_push,
    output t_terms                   o_q_data
);
    logic signed [DATA_W-1:0] r_integral, n_integral;
    logic signed [DATA_W-1:0] r_prev_meas, n_prev_meas;
    logic                     accept;
    logic                     is_clear;
    logic signed [WIDE_W-1:0] diff;
    logic signed [WIDE_W-1:0] integ_sum;
    logic signed [DATA_W-1:0] perr;
    logic signed [DATA_W-1:0] integ_new;
    logic signed [WIDE_W-1:0] derr;

    // A word is taken whenever the term queue has room.
    assign o_full   = i_q_full;
    assign accept   = i_push & ~i_q_full;
    assign is_clear = (t_op'(i_operation) == OP_CLEAR);

    // Error and integral formed at 17 bits before clamping; derivative left unclamped.
    always_comb begin
        diff      = WIDE_W'(i_target) - WIDE_W'(i_measured);
        perr      = clamp_lim(diff, i_clamp.err_lower, i_clamp.err_upper);
        integ_sum = WIDE_W'(r_integral) + WIDE_W'(perr);
        integ_new = clamp_lim(integ_sum, i_clamp.integ_lower, i_clamp.integ_upper);
        derr      = WIDE_W'(r_prev_meas) - WIDE_W'(i_measured);
    end

    // State update and queue write.
    always_comb begin
        n_integral  = r_integral;
        n_prev_meas = r_prev_meas;
        o_q_push    = 1'b0;
        if (accept) begin
            if (is_clear) begin
                n_integral = '0;
            end else begin
                n_integral  = integ_new;
                n_prev_meas = i_measured;
                o_q_push    = 1'b1;
            end
        end
    end

    assign o_q_data.perr  = perr;
    assign o_q_data.integ = integ_new;
    assign o_q_data.derr  = derr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integral  <= '0;
            r_prev_meas <= '0;
        end else begin
            r_integral  <= n_integral;
            r_prev_meas <= n_prev_meas;
        end
    end

    // A clear empties the integral and queues nothing.
    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && is_clear) |=> (r_integral == '0))
        else $error("integral not cleared after clear word");

    a_clear_no_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && is_clear) |-> !o_q_push)
        else $error("clear word produced queued terms");

endmodule

@@ src/pidct_back.sv @@
// Back of the PID controller: multiplies the queued terms by the gains, sums,
// scales and saturates, and holds results in an output queue.
// Uses pidct_pkg and pidct_fifo.
module pidct_back
    import pidct_pkg::*;
#(
    parameter int OUT_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_gain_cfg                i_gain,
    input  logic                     i_q_empty,
    input  t_terms                   i_q_data,
    output logic                     o_q_pop,
    input  logic                     i_pop,
    output logic                     o_empty,
    output logic signed [DATA_W-1:0] o_drive
);
    localparam int PROD_W = 2 * DATA_W;
    localparam int PRODD_W = DATA_W + WIDE_W;
    localparam int SUM_W = PRODD_W + 2;
    localparam int SHR_W = SUM_W - FRAC_W;
    localparam int CNT_W = $clog2(OUT_DEPTH + 1);
    localparam int OCC_W = CNT_W + 1;

    logic signed [PROD_W-1:0]  r_prod_p, n_prod_p;
    logic signed [PROD_W-1:0]  r_prod_i, n_prod_i;
    logic signed [PRODD_W-1:0] r_prod_d, n_prod_d;
    logic                      r_a_valid;
    logic signed [SUM_W-1:0]   sum;
    logic signed [SUM_W-1:0]   biased;
    logic signed [SHR_W-1:0]   quot;
    logic signed [DATA_W-1:0]  sat;
    logic [CNT_W-1:0]          out_count;
    logic [OCC_W-1:0]          occupancy;
    logic                      out_full;
    logic [DATA_W-1:0]         out_word;

    // Take terms only when the result queue can absorb everything in flight.
    assign occupancy = OCC_W'(out_count) + OCC_W'(r_a_valid);
    assign o_q_pop   = ~i_q_empty & (occupancy < OCC_W'(OUT_DEPTH));

    // Multiply stage.
    always_comb begin
        n_prod_p = i_gain.prop * i_q_data.perr;
        n_prod_i = i_gain.integ * i_q_data.integ;
        n_prod_d = i_gain.deriv * i_q_data.derr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= o_q_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_prod_p <= n_prod_p;
            r_prod_i <= n_prod_i;
            r_prod_d <= n_prod_d;
        end
    end

    // Sum, divide by 256 toward zero, saturate to 16 bits.
    always_comb begin
        sum    = SUM_W'(r_prod_p) + SUM_W'(r_prod_i) + SUM_W'(r_prod_d);
        biased = sum + (sum[SUM_W-1] ? SUM_W'(255) : SUM_W'(0));
        quot   = SHR_W'(biased >>> FRAC_W);
        if (quot > SHR_W'(32767)) begin
            sat = 16'sh7FFF;
        end else if (quot < -SHR_W'(32768)) begin
            sat = 16'sh8000;
        end else begin
            sat = quot[DATA_W-1:0];
        end
    end

    // Result queue.
    pidct_fifo #(
        .WIDTH (DATA_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (r_a_valid),
        .i_push_data (sat),
        .i_pop       (i_pop),
        .o_pop_data  (out_word),
        .o_full      (out_full),
        .o_empty     (o_empty),
        .o_count     (out_count)
    );

    assign o_drive = out_word;

    // A finished word always finds room in the result queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid |-> !out_full)
        else $error("result queue overflow");

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        occupancy <= OCC_W'(OUT_DEPTH))
        else $error("results in flight exceed queue depth");

endmodule
